// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the pixel stream blitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, switched off while in reset
`define BMPBLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpblt assertion failed");

// Next-cycle implication, sampled on clk, switched off while in reset
`define BMPBLT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpblt assertion failed");

`endif

// File: hdl/bmpblt_pkg.sv
// Types and constants shared by the pixel stream blitter modules.
package bmpblt_pkg;

    localparam int DIM_W     = 12;   // image width / height magnitude
    localparam int ORIGIN_W  = 13;   // signed screen origin
    localparam int COORD_W   = 12;   // on-screen coordinate (screen up to 4095)
    localparam int SCOORD_W  = 15;   // signed intermediate screen coordinate
    localparam int PROD_W    = 2 * COORD_W;
    localparam int FB_ADDR_W = 19;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MAG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_UP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd6;

    typedef struct packed {
        logic [DIM_W-1:0]           width_magnitude;
        logic                       mirror_x;
        logic [DIM_W-1:0]           height_magnitude;
        logic                       bottom_up;
        logic                       has_alpha;
        logic signed [ORIGIN_W-1:0] origin_x;
        logic signed [ORIGIN_W-1:0] origin_y;
    } cfg_t;

    // Completed pixel from the byte assembler, coordinates zero when off screen
    typedef struct packed {
        logic               produce;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic               vis;
        logic               last;
        logic [COLOR_W-1:0] color;
    } pix_t;

endpackage

// File: hdl/bmpblt_stream_ctl.sv
// Byte assembler: pixel phase, row/column/padding counters and screen coordinates.
module bmpblt_stream_ctl #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bmpblt_pkg::cfg_t    cfg,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output bmpblt_pkg::pix_t    pix
);
    import bmpblt_pkg::*;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_ALPHA = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [7:0]          blue_reg, blue_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          red_reg, red_next;
    logic [DIM_W-1:0]    col_reg, col_next;
    logic [DIM_W-1:0]    row_reg, row_next;
    logic [1:0]          pad_reg, pad_next;

    logic [DIM_W-1:0]    w_eff;
    logic [DIM_W-1:0]    h_eff;
    logic [1:0]          pad_needed;
    logic [1:0]          pad_inc;
    logic                in_padding;
    logic                col_done;
    logic                row_done;
    logic [DIM_W-1:0]    row_wrap;
    logic                produce;
    logic [7:0]          alpha_b;
    logic [7:0]          red_b;
    logic signed [SCOORD_W-1:0] ox_ext, oy_ext, w_ext, h_ext, col_ext, row_ext;
    logic signed [SCOORD_W-1:0] sx_full, sy_full;
    logic                vis;

    // Effective sizes: zero acts as one
    assign w_eff      = (cfg.width_magnitude == '0) ? DIM_W'(1) : cfg.width_magnitude;
    assign h_eff      = (cfg.height_magnitude == '0) ? DIM_W'(1) : cfg.height_magnitude;
    assign pad_needed = cfg.has_alpha ? 2'd0 : w_eff[1:0];
    assign pad_inc    = pad_reg + 2'd1;
    assign in_padding = (phase_reg == PH_BLUE) && (col_reg >= w_eff);
    assign col_done   = ({1'b0, col_reg} + (DIM_W+1)'(1)) >= {1'b0, w_eff};
    assign row_done   = ({1'b0, row_reg} + (DIM_W+1)'(1)) >= {1'b0, h_eff};
    assign row_wrap   = row_done ? '0 : row_reg + DIM_W'(1);

    // Byte routing for the completing byte
    assign red_b   = (phase_reg == PH_RED) ? data_byte : red_reg;
    assign alpha_b = (phase_reg == PH_ALPHA) ? data_byte : 8'd0;
    assign produce = !in_padding &&
                     ((phase_reg == PH_ALPHA) || (phase_reg == PH_RED && !cfg.has_alpha));

    // Screen coordinates
    assign ox_ext  = SCOORD_W'(cfg.origin_x);
    assign oy_ext  = SCOORD_W'(cfg.origin_y);
    assign w_ext   = $signed({{(SCOORD_W-DIM_W){1'b0}}, w_eff});
    assign h_ext   = $signed({{(SCOORD_W-DIM_W){1'b0}}, h_eff});
    assign col_ext = $signed({{(SCOORD_W-DIM_W){1'b0}}, col_reg});
    assign row_ext = $signed({{(SCOORD_W-DIM_W){1'b0}}, row_reg});
    assign sx_full = cfg.mirror_x  ? ox_ext + w_ext - SCOORD_W'(1) - col_ext : ox_ext + col_ext;
    assign sy_full = cfg.bottom_up ? oy_ext + h_ext - SCOORD_W'(1) - row_ext : oy_ext + row_ext;
    assign vis = !sx_full[SCOORD_W-1] && !sy_full[SCOORD_W-1] &&
                 (sx_full < SCOORD_W'(SCREEN_WIDTH)) && (sy_full < SCOORD_W'(SCREEN_HEIGHT));

    always_comb
    begin
        pix.produce = produce;
        pix.sx      = vis ? sx_full[COORD_W-1:0] : '0;
        pix.sy      = vis ? sy_full[COORD_W-1:0] : '0;
        pix.vis     = vis;
        pix.last    = col_done && row_done;
        pix.color   = {alpha_b, red_b, green_reg, blue_reg};
    end

    // Next-state logic for one accepted byte
    always_comb
    begin
        phase_next = phase_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        red_next   = red_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        if (accept)
        begin
            if (in_padding)
            begin
                pad_next = pad_inc;
                if (pad_inc >= pad_needed || pad_inc == 2'd0)
                begin
                    col_next = '0;
                    pad_next = '0;
                    row_next = row_wrap;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_BLUE:
                    begin
                        blue_next  = data_byte;
                        phase_next = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        green_next = data_byte;
                        phase_next = PH_RED;
                    end
                    PH_RED:
                    begin
                        red_next   = data_byte;
                        phase_next = cfg.has_alpha ? PH_ALPHA : PH_BLUE;
                    end
                    PH_ALPHA:
                    begin
                        phase_next = PH_BLUE;
                    end
                endcase
                // Column advance once a pixel completes
                if (produce)
                begin
                    if (!col_done)
                    begin
                        col_next = col_reg + DIM_W'(1);
                    end
                    else if (pad_needed == 2'd0)
                    begin
                        col_next = '0;
                        pad_next = '0;
                        row_next = row_wrap;
                    end
                    else
                    begin
                        col_next = w_eff;
                        pad_next = '0;
                    end
                end
            end
        end
    end

    // Stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BLUE;
            blue_reg  <= '0;
            green_reg <= '0;
            red_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            pad_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

// File: hdl/bmp_pixel_stream_blitter.sv
// Top level of the BMP pixel stream blitter: config, pipeline and framebuffer address.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+--------------------------------------------------
//  in      | in_valid / in_stall    | data_byte
//  out     | out_valid / out_stall  | fb_address, pixel_color, on_screen, last_pixel
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte is taken per cycle unless in_stall is high; a pixel's result is registered
// in the coordinate stage, then after the row-times-width multiply and add.
// rst_n clears stream counters and both valid flags; config registers go to defaults.
// out_stall holds the result register; in_stall rises only when both stages are full.
// cfg_ready is always high.
`include "assert_macros.svh"

module bmp_pixel_stream_blitter #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             data_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [bmpblt_pkg::FB_ADDR_W-1:0]       fb_address,
    output logic [bmpblt_pkg::COLOR_W-1:0]         pixel_color,
    output logic                                   on_screen,
    output logic                                   last_pixel,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bmpblt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmpblt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bmpblt_pkg::*;

    localparam int FB_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;

    cfg_t                 cfg_reg;
    pix_t                 pix;
    pix_t                 s1_reg;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FB_ADDR_W-1:0] fb_address_reg;
    logic [COLOR_W-1:0]   pixel_color_reg;
    logic                 on_screen_reg;
    logic                 last_pixel_reg;
    logic                 out_free;
    logic                 s1_free;
    logic                 accept;
    logic [PROD_W-1:0]    addr_full;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || out_free;
    assign in_stall  = !s1_free;
    assign accept    = in_valid && s1_free;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_magnitude  <= DIM_W'(1);
            cfg_reg.mirror_x         <= 1'b0;
            cfg_reg.height_magnitude <= DIM_W'(1);
            cfg_reg.bottom_up        <= 1'b1;
            cfg_reg.has_alpha        <= 1'b0;
            cfg_reg.origin_x         <= '0;
            cfg_reg.origin_y         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH_MAG:  cfg_reg.width_magnitude  <= cfg_data[DIM_W-1:0];
                CFG_MIRROR_X:   cfg_reg.mirror_x         <= cfg_data[0];
                CFG_HEIGHT_MAG: cfg_reg.height_magnitude <= cfg_data[DIM_W-1:0];
                CFG_BOTTOM_UP:  cfg_reg.bottom_up        <= cfg_data[0];
                CFG_HAS_ALPHA:  cfg_reg.has_alpha        <= cfg_data[0];
                CFG_ORIGIN_X:   cfg_reg.origin_x         <= $signed(cfg_data);
                CFG_ORIGIN_Y:   cfg_reg.origin_y         <= $signed(cfg_data);
                default:        ;
            endcase
        end
    end

    // Byte assembly and coordinates
    bmpblt_stream_ctl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_stream_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .data_byte (data_byte),
        .pix       (pix)
    );

    // Framebuffer address from the registered coordinates
    assign addr_full = PROD_W'(s1_reg.sy) * PROD_W'(SCREEN_WIDTH) + PROD_W'(s1_reg.sx);

    assign s1_valid_next  = s1_free ? (accept && pix.produce) : s1_valid_reg;
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (s1_free && accept && pix.produce)
        begin
            s1_reg <= pix;
        end
        if (out_free && s1_valid_reg)
        begin
            fb_address_reg  <= FB_ADDR_W'(addr_full);
            pixel_color_reg <= s1_reg.color;
            on_screen_reg   <= s1_reg.vis;
            last_pixel_reg  <= s1_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fb_address  = fb_address_reg;
    assign pixel_color = pixel_color_reg;
    assign on_screen   = on_screen_reg;
    assign last_pixel  = last_pixel_reg;

    // Checks
    `BMPBLT_ASSERT_IMP(a_offscreen_zero_addr, out_valid_reg && !on_screen_reg, fb_address_reg == '0)
    `BMPBLT_ASSERT_IMP(a_addr_in_range, out_valid && on_screen, fb_address < FB_ADDR_W'(FB_SIZE))
    `BMPBLT_ASSERT_NXT(a_pixel_captured, accept && pix.produce, s1_valid_reg)

endmodule

// File: dv/bmp_pixel_stream_blitter_tb.sv
// Self-checking testbench for the BMP pixel stream blitter: byte driver, pixel checker.
`timescale 1ns / 1ps

module bmp_pixel_stream_blitter_tb;
    import bmpblt_pkg::*;

    localparam int SCREEN_W       = 800;
    localparam int SCREEN_H       = 480;
    localparam int RANDOM_BYTES   = 1200;
    localparam int CALM_FROM      = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int SMALL_IMAGE    = 64;

    // Position of the next byte within a pixel
    localparam logic [1:0] SLOT_BLUE  = 2'd0;
    localparam logic [1:0] SLOT_GREEN = 2'd1;
    localparam logic [1:0] SLOT_RED   = 2'd2;
    localparam logic [1:0] SLOT_ALPHA = 2'd3;

    typedef struct packed {
        logic [FB_ADDR_W-1:0] address;
        logic [COLOR_W-1:0]   colour;
        logic                 visible;
        logic                 last;
    } pixel_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [7:0]            data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [FB_ADDR_W-1:0]  fb_address;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  on_screen;
    logic                  last_pixel;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the configuration registers, reset values
    logic [DIM_W-1:0]           img_width  = 1;
    logic                       flip_x     = 1'b0;
    logic [DIM_W-1:0]           img_height = 1;
    logic                       rows_up    = 1'b1;
    logic                       alpha_on   = 1'b0;
    logic signed [ORIGIN_W-1:0] left_edge  = '0;
    logic signed [ORIGIN_W-1:0] top_edge   = '0;

    // Predicted stream position and partly assembled pixel
    logic [1:0]       byte_slot = SLOT_BLUE;
    logic [7:0]       blue_val  = '0;
    logic [7:0]       green_val = '0;
    logic [7:0]       red_val   = '0;
    logic [DIM_W-1:0] column    = '0;
    logic [DIM_W-1:0] row       = '0;
    logic [1:0]       pad_seen  = '0;

    pixel_t     expected_pixels[$];
    logic [7:0] byte_queue[$];
    int         bytes_issued   = 0;
    int         bytes_accepted = 0;
    int         fed_bytes      = 0;
    int         mismatches     = 0;
    int         idle_cycles    = 0;
    int         in_gap         = 0;
    int         out_gap        = 0;
    bit         in_idling      = 1'b0;
    bit         out_idling     = 1'b0;

    bmp_pixel_stream_blitter #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fb_address  (fb_address),
        .pixel_color (pixel_color),
        .on_screen   (on_screen),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // End of a row: back to column 0, row wraps once the image height is reached
    task automatic close_row(input int h);
        column   = '0;
        pad_seen = '0;
        if (int'(row) + 1 >= h)
            row = '0;
        else
            row = row + 1'b1;
    endtask

    // Advance the stream by one byte, queueing the pixel it completes
    task automatic predict_pixel(input logic [7:0] b);
        int         w;
        int         h;
        int         pad_due;
        int         c;
        int         r;
        int         sx;
        int         sy;
        logic [7:0] alpha_val;
        pixel_t     px;
        w       = (img_width == 0) ? 1 : int'(img_width);
        h       = (img_height == 0) ? 1 : int'(img_height);
        pad_due = alpha_on ? 0 : (w % 4);
        c       = int'(column);
        r       = int'(row);
        // row padding: value ignored, no pixel; an unexpected pad byte ends the row
        if (byte_slot == SLOT_BLUE && c >= w)
        begin
            pad_seen = pad_seen + 1'b1;
            if (int'(pad_seen) >= pad_due || pad_seen == 2'd0)
                close_row(h);
        end
        else if (byte_slot == SLOT_BLUE)
        begin
            blue_val  = b;
            byte_slot = SLOT_GREEN;
        end
        else if (byte_slot == SLOT_GREEN)
        begin
            green_val = b;
            byte_slot = SLOT_RED;
        end
        else if (byte_slot == SLOT_RED && alpha_on)
        begin
            red_val   = b;
            byte_slot = SLOT_ALPHA;
        end
        else
        begin
            // alpha slot completes the pixel even if alpha was switched off meanwhile
            if (byte_slot == SLOT_RED)
            begin
                red_val   = b;
                alpha_val = '0;
            end
            else
                alpha_val = b;
            byte_slot = SLOT_BLUE;
            sx = flip_x  ? int'(left_edge) + w - 1 - c : int'(left_edge) + c;
            sy = rows_up ? int'(top_edge) + h - 1 - r : int'(top_edge) + r;
            px.visible = (sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H);
            px.address = px.visible ? FB_ADDR_W'(sy * SCREEN_W + sx) : '0;
            px.colour  = {alpha_val, red_val, green_val, blue_val};
            px.last    = (c + 1 >= w) && (r + 1 >= h);
            expected_pixels.push_back(px);
            if (c + 1 >= w)
            begin
                if (pad_due == 0)
                    close_row(h);
                else
                begin
                    column   = DIM_W'(w);
                    pad_seen = '0;
                end
            end
            else
                column = column + 1'b1;
        end
    endtask

    // Compare one pixel transaction against the oldest prediction
    task automatic check_pixel();
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected pixel: addr %0d colour %08h vis %0b last %0b",
                         $time, fb_address, pixel_color, on_screen, last_pixel);
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (fb_address !== want.address || pixel_color !== want.colour ||
                on_screen !== want.visible || last_pixel !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: pixel mismatch: expected addr %0d colour %08h vis %0b last %0b",
                             $time, want.address, want.colour, want.visible, want.last);
                    $display("%0t:                      got addr %0d colour %08h vis %0b last %0b",
                             $time, fb_address, pixel_color, on_screen, last_pixel);
                end
            end
        end
    endtask

    // Byte driver: feeds the DUT from the pending queue, with bursts of idle cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= '0;
            in_gap    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixel(data_byte);
                bytes_accepted++;
            end
            // a stalled transaction is held unchanged
            if (!(in_valid && in_stall))
            begin
                if (in_gap != 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (in_idling && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= $urandom_range(0, 3);
                end
                else if (byte_queue.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    data_byte <= byte_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Pixel monitor: checks accepted results, stalls in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_pixel();
            if (out_gap != 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else if (out_idling && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_issued++;
    endtask

    task automatic push_random(input int n);
        repeat (n)
            push_byte(8'($urandom_range(0, 255)));
        fed_bytes += n;
    endtask

    task automatic wait_accepted();
        while (bytes_accepted != bytes_issued)
            @(posedge clk);
    endtask

    // All bytes taken, all pixels out, pipeline given time to empty
    task automatic wait_idle();
        wait_accepted();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_WIDTH_MAG:  img_width  = value[DIM_W-1:0];
            CFG_MIRROR_X:   flip_x     = value[0];
            CFG_HEIGHT_MAG: img_height = value[DIM_W-1:0];
            CFG_BOTTOM_UP:  rows_up    = value[0];
            CFG_HAS_ALPHA:  alpha_on   = value[0];
            CFG_ORIGIN_X:   left_edge  = value[ORIGIN_W-1:0];
            CFG_ORIGIN_Y:   top_edge   = value[ORIGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int w, input bit mir, input int h, input bit up,
                              input bit alp, input int ox, input int oy);
        write_reg(CFG_WIDTH_MAG, w);
        write_reg(CFG_MIRROR_X, mir);
        write_reg(CFG_HEIGHT_MAG, h);
        write_reg(CFG_BOTTOM_UP, up);
        write_reg(CFG_HAS_ALPHA, alp);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit stream_at_start();
        return byte_slot == SLOT_BLUE && column == 0 && row == 0 && pad_seen == 0;
    endfunction

    // Mostly small sizes, now and then zero or the extremes
    function automatic int pick_size(input int small_max);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 4095;
            2:       return int'($urandom_range(1, 4095));
            default: return int'($urandom_range(1, small_max));
        endcase
    endfunction

    // Origins around the screen edges, the register limits and anywhere
    function automatic int pick_origin(input int span);
        case ($urandom_range(0, 5))
            0:       return -4096;
            1:       return 4095;
            2:       return int'($urandom_range(0, 12)) - 6;
            3:       return span - int'($urandom_range(0, 8));
            4:       return int'($urandom_range(0, 8191)) - 4096;
            default: return int'($urandom_range(0, span - 1));
        endcase
    endfunction

    initial
    begin : stimulus
        int phase_no;
        int w_eff;
        int h_eff;
        int image_bytes;
        int n;
        int fill;
        bit calm;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one 24-bit pixel of extreme byte values, then its pad byte
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h5A);
        wait_idle();

        // 32-bit, mirrored, top-down at the bottom-right corner: one pixel just off screen
        set_config(2, 1'b1, 1, 1'b0, 1'b1, 799, 479);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'hFF);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h04);
        push_byte(8'h00);
        wait_idle();

        // zero width, alpha switched off mid-pixel: the next byte is still its alpha
        set_config(0, 1'b0, 1, 1'b1, 1'b1, 0, 0);
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(8'h33);
        wait_idle();
        write_reg(CFG_HAS_ALPHA, 0);
        cfg_valid <= 1'b0;
        push_byte(8'h44);
        wait_idle();
        // padding now due, but 32-bit mode means none: the pad byte ends the row
        write_reg(CFG_HAS_ALPHA, 1);
        cfg_valid <= 1'b0;
        push_byte(8'h55);

        // random images under changing settings
        fed_bytes = 0;
        phase_no  = 0;
        while (fed_bytes < RANDOM_BYTES)
        begin
            wait_idle();
            calm       = fed_bytes >= CALM_FROM;
            in_idling  = !calm && $urandom_range(0, 3) != 0;
            out_idling = !calm && $urandom_range(0, 3) != 0;
            if (phase_no == 0)
                set_config(4095, 1'b1, 4095, 1'b1, 1'b0, -4096, 4095);
            else if (phase_no == 1)
                set_config(0, 1'b0, 0, 1'b0, 1'b0, 4095, -4096);
            else
                set_config(pick_size(7), 1'($urandom_range(0, 1)), pick_size(5),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           pick_origin(SCREEN_W), pick_origin(SCREEN_H));
            w_eff       = (img_width == 0) ? 1 : int'(img_width);
            h_eff       = (img_height == 0) ? 1 : int'(img_height);
            image_bytes = (w_eff * (alpha_on ? 4 : 3) + (alpha_on ? 0 : w_eff % 4)) * h_eff;
            if (w_eff * h_eff > SMALL_IMAGE)
                // large image: only its first bytes
                push_random($urandom_range(1, 200));
            else
            begin
                // close the image left open under the old settings, byte by byte
                fill = 0;
                while (!stream_at_start() && fill < 400)
                begin
                    push_random(1);
                    wait_accepted();
                    fill++;
                end
                n = image_bytes * $urandom_range(1, 2);
                if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(1, n - 1);      // image cut short
                else if ($urandom_range(0, 9) == 0)
                    n = n + $urandom_range(1, 5);      // stray bytes after the image
                push_random(n);
            end
            phase_no++;
        end

        in_idling  = 1'b0;
        out_idling = 1'b0;
        wait_accepted();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/bmpblt_pkg.sv
hdl/bmpblt_stream_ctl.sv
hdl/bmp_pixel_stream_blitter.sv
dv/bmp_pixel_stream_blitter_tb.sv
